[design/luma_stats_motion_detector_assert.svh]
// assertion macros for the luma statistics block
// both expect clk and rst_n in the scope where they are used
`ifndef LUMA_STATS_MOTION_DETECTOR_ASSERT_SVH
`define LUMA_STATS_MOTION_DETECTOR_ASSERT_SVH

// same-cycle implication, off during reset
`define LSMD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("luma stats check failed");

// next-cycle implication, off during reset
`define LSMD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("luma stats check failed");

`endif

[design/lsmd_pkg.sv]
`default_nettype none

package lsmd_pkg;

    // frame store size
    localparam int unsigned MAX_PIXELS = 19200;

    // derived widths
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned TAG_W   = 32;
    localparam int unsigned IDX_W   = $clog2(MAX_PIXELS + 1);
    localparam int unsigned ADDR_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int unsigned SUM_W   = IDX_W + PIX_W;
    localparam int unsigned SQ_W    = IDX_W + 2 * PIX_W;
    localparam int unsigned PM_W    = 10;
    localparam int unsigned MEAN4_W = 10;
    localparam int unsigned VAR_W   = 16;
    localparam int unsigned PMUL_W  = IDX_W + PM_W;
    localparam int unsigned DIVD_A  = (SUM_W + 2 > SQ_W) ? SUM_W + 2 : SQ_W;
    localparam int unsigned DIVD_W  = (DIVD_A > PMUL_W) ? DIVD_A : PMUL_W;
    localparam int unsigned CNT_W   = $clog2(DIVD_W);
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [PIX_W-1:0]     pix_t;
    typedef logic [TAG_W-1:0]     tag_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [SUM_W-1:0]     sum_t;
    typedef logic [SQ_W-1:0]      sq_t;
    typedef logic [DIVD_W-1:0]    divd_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [CFG_W-1:0]     cfg_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [PM_W-1:0]      pm_t;
    typedef logic [MEAN4_W-1:0]   mean4_t;
    typedef logic [VAR_W-1:0]     var_t;

    localparam divd_t PERMILLE = divd_t'(1000);

    // register indexes of the configuration port
    localparam cfg_idx_t REG_DARK_THR   = cfg_idx_t'(0);
    localparam cfg_idx_t REG_SAT_THR    = cfg_idx_t'(1);
    localparam cfg_idx_t REG_MOTION_THR = cfg_idx_t'(2);

    // threshold reset values
    localparam cfg_t DARK_THR_RST   = cfg_t'(16);
    localparam cfg_t SAT_THR_RST    = cfg_t'(240);
    localparam cfg_t MOTION_THR_RST = cfg_t'(12);

    // end-of-frame division sequence
    typedef enum logic [2:0] {
        OP_MEAN   = 3'd0,
        OP_MEANSQ = 3'd1,
        OP_DARK   = 3'd2,
        OP_SAT    = 3'd3,
        OP_MOTION = 3'd4
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_store;
        op_t  div_op;
        logic load_out;
        logic frame_clear;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
        logic div_done;
    } status_t;

    // one result word
    typedef struct packed {
        tag_t   frame_tag;
        mean4_t mean_luma_x4;
        var_t   luma_variance;
        pm_t    dark_permille;
        pm_t    saturated_permille;
        pm_t    motion_permille;
        logic   motion_valid;
    } result_t;

endpackage

`default_nettype wire

[design/lsmd_pixel_if.sv]
`default_nettype none

interface lsmd_pixel_if;
    logic              valid;
    logic              ready;
    lsmd_pkg::pix_t    pixel;
    logic              end_of_frame;
    lsmd_pkg::tag_t    frame_number;

    modport source (output valid, output pixel, output end_of_frame, output frame_number,
                    input ready);
    modport sink   (input valid, input pixel, input end_of_frame, input frame_number,
                    output ready);
endinterface

`default_nettype wire

[design/lsmd_result_if.sv]
`default_nettype none

interface lsmd_result_if;
    logic                valid;
    logic                ready;
    lsmd_pkg::tag_t      frame_tag;
    lsmd_pkg::mean4_t    mean_luma_x4;
    lsmd_pkg::var_t      luma_variance;
    lsmd_pkg::pm_t       dark_permille;
    lsmd_pkg::pm_t       saturated_permille;
    lsmd_pkg::pm_t       motion_permille;
    logic                motion_valid;

    modport source (output valid, output frame_tag, output mean_luma_x4,
                    output luma_variance, output dark_permille, output saturated_permille,
                    output motion_permille, output motion_valid, input ready);
    modport sink   (input valid, input frame_tag, input mean_luma_x4,
                    input luma_variance, input dark_permille, input saturated_permille,
                    input motion_permille, input motion_valid, output ready);
endinterface

`default_nettype wire

[design/lsmd_ram.sv]
`default_nettype none

module lsmd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/lsmd_div.sv]
`default_nettype none

module lsmd_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire lsmd_pkg::divd_t dividend,
    input  wire lsmd_pkg::idx_t  divisor,
    output lsmd_pkg::divd_t     quotient,
    output logic                busy,
    output logic                done
);

    logic              run_reg,  run_next;
    logic              done_reg, done_next;
    lsmd_pkg::cnt_t    cnt_reg,  cnt_next;
    lsmd_pkg::idx_t    rem_reg,  rem_next;
    lsmd_pkg::idx_t    den_reg,  den_next;
    lsmd_pkg::divd_t   quo_reg,  quo_next;

    logic [lsmd_pkg::IDX_W:0] trial;
    logic [lsmd_pkg::IDX_W:0] trial_sub;
    logic                     fits;

    // one restoring step per cycle, msb first
    always_comb
    begin
        trial     = {rem_reg, quo_reg[lsmd_pkg::DIVD_W-1]};
        trial_sub = trial - {1'b0, den_reg};
        fits      = (trial >= {1'b0, den_reg});

        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            run_next = 1'b1;
            cnt_next = lsmd_pkg::cnt_t'(lsmd_pkg::DIVD_W - 1);
            rem_next = '0;
            den_next = divisor;
            quo_next = dividend;
        end
        else if (run_reg)
        begin
            rem_next = fits ? trial_sub[lsmd_pkg::IDX_W-1:0] : trial[lsmd_pkg::IDX_W-1:0];
            quo_next = {quo_reg[lsmd_pkg::DIVD_W-2:0], fits};
            cnt_next = cnt_reg - lsmd_pkg::cnt_t'(1);
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign busy     = run_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

[design/lsmd_datapath.sv]
`default_nettype none

module lsmd_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lsmd_pkg::cmd_t      cmd,
    output lsmd_pkg::status_t       status,
    input  wire lsmd_pkg::pix_t      pixel,
    input  wire lsmd_pkg::tag_t      frame_number,
    input  wire logic               cfg_we,
    input  wire lsmd_pkg::cfg_idx_t  cfg_index,
    input  wire lsmd_pkg::cfg_t      cfg_data,
    output lsmd_pkg::result_t       result
);

    // configuration
    lsmd_pkg::cfg_t dark_thr_reg, sat_thr_reg, motion_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_thr_reg   <= lsmd_pkg::DARK_THR_RST;
            sat_thr_reg    <= lsmd_pkg::SAT_THR_RST;
            motion_thr_reg <= lsmd_pkg::MOTION_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lsmd_pkg::REG_DARK_THR:   dark_thr_reg   <= cfg_data;
                lsmd_pkg::REG_SAT_THR:    sat_thr_reg    <= cfg_data;
                lsmd_pkg::REG_MOTION_THR: motion_thr_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // stage 0: index, store read, fill check
    lsmd_pkg::idx_t  pixel_index_reg, pixel_index_next;
    lsmd_pkg::idx_t  fill_reg, fill_next;
    lsmd_pkg::tag_t  tag_reg;
    logic            in_range;
    logic            rd_en;
    lsmd_pkg::pix_t  ram_q;

    assign in_range = (pixel_index_reg < lsmd_pkg::idx_t'(lsmd_pkg::MAX_PIXELS));
    assign rd_en    = cmd.accept && in_range;

    always_comb
    begin
        pixel_index_next = pixel_index_reg;
        if (cmd.frame_clear)
        begin
            pixel_index_next = '0;
        end
        else if (rd_en)
        begin
            pixel_index_next = pixel_index_reg + lsmd_pkg::idx_t'(1);
        end
    end

    // stage 1 registers
    logic            s1_valid_reg;
    logic            s1_in_range_reg;
    logic            s1_old_ok_reg;
    lsmd_pkg::pix_t  s1_pixel_reg;
    lsmd_pkg::addr_t s1_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            pixel_index_reg <= '0;
            fill_reg        <= '0;
        end
        else
        begin
            s1_valid_reg    <= cmd.accept;
            pixel_index_reg <= pixel_index_next;
            fill_reg        <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            s1_pixel_reg    <= pixel;
            s1_in_range_reg <= in_range;
            s1_addr_reg     <= pixel_index_reg[lsmd_pkg::ADDR_W-1:0];
            s1_old_ok_reg   <= (pixel_index_reg < fill_reg);
            tag_reg         <= frame_number;
        end
    end

    // previous frame store; entries at or past the fill mark read as zero
    lsmd_ram #(
        .WIDTH (lsmd_pkg::PIX_W),
        .DEPTH (lsmd_pkg::MAX_PIXELS)
    ) u_prev_frame (
        .clk   (clk),
        .we    (s1_valid_reg && s1_in_range_reg),
        .waddr (s1_addr_reg),
        .wdata (s1_pixel_reg),
        .re    (rd_en),
        .raddr (pixel_index_reg[lsmd_pkg::ADDR_W-1:0]),
        .rdata (ram_q)
    );

    // stage 1: accumulate
    logic            upd;
    lsmd_pkg::pix_t  old_px;
    lsmd_pkg::pix_t  abs_diff;
    logic [2*lsmd_pkg::PIX_W-1:0] px_sq;
    lsmd_pkg::sum_t  sum_reg;
    lsmd_pkg::sq_t   sq_reg;
    lsmd_pkg::idx_t  dark_reg, sat_reg, chg_reg;
    logic            have_prev_reg;

    assign upd      = s1_valid_reg && s1_in_range_reg;
    assign old_px   = s1_old_ok_reg ? ram_q : '0;
    assign abs_diff = (s1_pixel_reg > old_px) ? (s1_pixel_reg - old_px)
                                              : (old_px - s1_pixel_reg);
    assign px_sq    = {{lsmd_pkg::PIX_W{1'b0}}, s1_pixel_reg}
                    * {{lsmd_pkg::PIX_W{1'b0}}, s1_pixel_reg};

    // store fills contiguously from position zero
    always_comb
    begin
        fill_next = fill_reg;
        if (upd && (lsmd_pkg::idx_t'(s1_addr_reg) == fill_reg))
        begin
            fill_next = fill_reg + lsmd_pkg::idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            sq_reg        <= '0;
            dark_reg      <= '0;
            sat_reg       <= '0;
            chg_reg       <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (cmd.frame_clear)
        begin
            sum_reg       <= '0;
            sq_reg        <= '0;
            dark_reg      <= '0;
            sat_reg       <= '0;
            chg_reg       <= '0;
            have_prev_reg <= 1'b1;
        end
        else if (upd)
        begin
            sum_reg <= sum_reg + lsmd_pkg::sum_t'(s1_pixel_reg);
            sq_reg  <= sq_reg + lsmd_pkg::sq_t'(px_sq);
            if (s1_pixel_reg < dark_thr_reg)
            begin
                dark_reg <= dark_reg + lsmd_pkg::idx_t'(1);
            end
            if (s1_pixel_reg > sat_thr_reg)
            begin
                sat_reg <= sat_reg + lsmd_pkg::idx_t'(1);
            end
            if (have_prev_reg && (abs_diff > motion_thr_reg))
            begin
                chg_reg <= chg_reg + lsmd_pkg::idx_t'(1);
            end
        end
    end

    // end of frame divisions, one shared divider
    lsmd_pkg::divd_t numer;
    lsmd_pkg::idx_t  denom;
    lsmd_pkg::divd_t quotient;
    logic            div_busy, div_done;

    always_comb
    begin
        case (cmd.div_op)
            lsmd_pkg::OP_MEAN:   numer = lsmd_pkg::divd_t'({sum_reg, 2'b00});
            lsmd_pkg::OP_MEANSQ: numer = lsmd_pkg::divd_t'(sq_reg);
            lsmd_pkg::OP_DARK:   numer = lsmd_pkg::divd_t'(dark_reg) * lsmd_pkg::PERMILLE;
            lsmd_pkg::OP_SAT:    numer = lsmd_pkg::divd_t'(sat_reg) * lsmd_pkg::PERMILLE;
            lsmd_pkg::OP_MOTION: numer = lsmd_pkg::divd_t'(chg_reg) * lsmd_pkg::PERMILLE;
            default:             numer = '0;
        endcase
        denom = (pixel_index_reg == '0) ? lsmd_pkg::idx_t'(1) : pixel_index_reg;
    end

    lsmd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (numer),
        .divisor  (denom),
        .quotient (quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    assign status.div_busy = div_busy;
    assign status.div_done = div_done;

    // quotients of the current frame
    lsmd_pkg::mean4_t q_mean4_reg;
    lsmd_pkg::var_t   q_meansq_reg;
    lsmd_pkg::pm_t    q_dark_reg, q_sat_reg, q_chg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            case (cmd.div_op)
                lsmd_pkg::OP_MEAN:   q_mean4_reg  <= quotient[lsmd_pkg::MEAN4_W-1:0];
                lsmd_pkg::OP_MEANSQ: q_meansq_reg <= quotient[lsmd_pkg::VAR_W-1:0];
                lsmd_pkg::OP_DARK:   q_dark_reg   <= quotient[lsmd_pkg::PM_W-1:0];
                lsmd_pkg::OP_SAT:    q_sat_reg    <= quotient[lsmd_pkg::PM_W-1:0];
                lsmd_pkg::OP_MOTION: q_chg_reg    <= quotient[lsmd_pkg::PM_W-1:0];
                default:             ;
            endcase
        end
    end

    // variance from floor mean of squares and floor mean
    lsmd_pkg::pix_t mean;
    lsmd_pkg::var_t mean_sq;

    assign mean    = q_mean4_reg[lsmd_pkg::MEAN4_W-1:2];
    assign mean_sq = {{lsmd_pkg::PIX_W{1'b0}}, mean} * {{lsmd_pkg::PIX_W{1'b0}}, mean};

    // output word register
    lsmd_pkg::result_t result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            result_reg.frame_tag          <= tag_reg;
            result_reg.mean_luma_x4       <= q_mean4_reg;
            result_reg.luma_variance      <= q_meansq_reg - mean_sq;
            result_reg.dark_permille      <= q_dark_reg;
            result_reg.saturated_permille <= q_sat_reg;
            result_reg.motion_permille    <= have_prev_reg ? q_chg_reg : '0;
            result_reg.motion_valid       <= have_prev_reg;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

[design/lsmd_ctrl.sv]
`default_nettype none

module lsmd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_eof,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire lsmd_pkg::status_t  status,
    output lsmd_pkg::cmd_t         cmd
);

    typedef enum logic [4:0] {
        S_RUN   = 5'b00001,
        S_FLUSH = 5'b00010,
        S_START = 5'b00100,
        S_WAIT  = 5'b01000,
        S_LOAD  = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    lsmd_pkg::op_t  op_reg, op_next;
    logic           out_valid_reg, out_valid_next;
    logic           accept;
    logic           load;
    logic           store;

    assign in_ready = (state_reg == S_RUN);
    assign accept   = in_valid && in_ready;
    assign load     = (state_reg == S_LOAD) && (!out_valid_reg || out_ready);
    assign store    = (state_reg == S_WAIT) && status.div_done;

    // sequencing of a frame end
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            S_RUN:
            begin
                if (accept && in_eof)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (store)
                begin
                    case (op_reg)
                        lsmd_pkg::OP_MEAN:   op_next = lsmd_pkg::OP_MEANSQ;
                        lsmd_pkg::OP_MEANSQ: op_next = lsmd_pkg::OP_DARK;
                        lsmd_pkg::OP_DARK:   op_next = lsmd_pkg::OP_SAT;
                        lsmd_pkg::OP_SAT:    op_next = lsmd_pkg::OP_MOTION;
                        default:             op_next = lsmd_pkg::OP_MEAN;
                    endcase
                    state_next = (op_reg == lsmd_pkg::OP_MOTION) ? S_LOAD : S_START;
                end
            end
            S_LOAD:
            begin
                if (load)
                begin
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
                op_next    = lsmd_pkg::OP_MEAN;
            end
        endcase
    end

    // output word valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            op_reg        <= lsmd_pkg::OP_MEAN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    assign cmd.accept      = accept;
    assign cmd.div_start   = (state_reg == S_START);
    assign cmd.div_store   = store;
    assign cmd.div_op      = op_reg;
    assign cmd.load_out    = load;
    assign cmd.frame_clear = load;

endmodule

`default_nettype wire

[design/luma_stats_motion_detector.sv]
// luma statistics and frame-difference motion detector
// pixel_in: one 8-bit luma word per handshake in raster order, end_of_frame on the
// last pixel, frame_number taken from that last pixel
// stats_out: one word per frame with mean x4, variance, dark, saturated and
// motion per-mille and the motion valid flag
// cfg port: cfg_we writes cfg_data[7:0] to threshold cfg_index (0 dark,
// 1 saturation, 2 motion); write only while the block is idle
// throughput: one pixel per cycle inside a frame; pixels past the frame store
// size are dropped but still end the frame
// frame end: after the last pixel is taken, the frame word is registered once five
// 31-step divisions have run in turn on one shared radix-2 divider;
// pixel_in.ready stays low until then
// the result sits in an output register, so a stalled receiver does not hold up the
// pixels of the next frame, only its frame end and the pixels that follow it
// reset: thresholds go to 16, 240 and 12, accumulators clear, and the previous
// frame store reads as zero through a fill mark; no clearing pass is needed
`default_nettype none
`include "luma_stats_motion_detector_assert.svh"

module luma_stats_motion_detector (
    input  wire logic              clk,
    input  wire logic              rst_n,
    lsmd_pixel_if.sink             pixel_in,
    lsmd_result_if.source          stats_out,
    input  wire logic              cfg_we,
    input  wire lsmd_pkg::cfg_idx_t cfg_index,
    input  wire lsmd_pkg::cfg_t     cfg_data
);

    lsmd_pkg::cmd_t    cmd;
    lsmd_pkg::status_t status;
    lsmd_pkg::result_t result;
    logic              in_ready;
    logic              out_valid;

    // sequencer
    lsmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_in.valid),
        .in_eof    (pixel_in.end_of_frame),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (stats_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // accumulators, frame store, divider
    lsmd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pixel        (pixel_in.pixel),
        .frame_number (pixel_in.frame_number),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result)
    );

    assign pixel_in.ready               = in_ready;
    assign stats_out.valid              = out_valid;
    assign stats_out.frame_tag          = result.frame_tag;
    assign stats_out.mean_luma_x4       = result.mean_luma_x4;
    assign stats_out.luma_variance      = result.luma_variance;
    assign stats_out.dark_permille      = result.dark_permille;
    assign stats_out.saturated_permille = result.saturated_permille;
    assign stats_out.motion_permille    = result.motion_permille;
    assign stats_out.motion_valid       = result.motion_valid;

    // no pixel taken while the divider runs
    `LSMD_ASSERT_IMPL(a_no_pixel_while_dividing, pixel_in.ready, !status.div_busy)
    // the last pixel closes the input for the frame end
    `LSMD_ASSERT_NEXT(a_eof_closes_input, cmd.accept && pixel_in.end_of_frame, !in_ready)
    // each division start sets the divider running
    `LSMD_ASSERT_NEXT(a_div_start_runs, cmd.div_start, status.div_busy)

endmodule

`default_nettype wire

[tb/luma_stats_motion_detector_tb.sv]
`timescale 1ns / 1ps

module luma_stats_motion_detector_tb;
    import lsmd_pkg::*;

    // index with no register behind it, writes there must change nothing
    localparam cfg_idx_t REG_SPARE = cfg_idx_t'(3);
    localparam int unsigned EOF_SETTLE = 200;
    localparam int unsigned PHASE_WORDS = 80;

    // per-frame statistics predictor and queue of expected frame words
    class frame_stats_tracker;
        cfg_t        dark_thr;
        cfg_t        sat_thr;
        cfg_t        motion_thr;
        int unsigned pix_count;
        int unsigned luma_total;
        int unsigned square_total;
        int unsigned dark_hits;
        int unsigned sat_hits;
        int unsigned change_hits;
        pix_t        last_frame [MAX_PIXELS];
        bit          have_last;
        result_t     pending_stats [$];
        int unsigned mismatches;

        function new();
            dark_thr = DARK_THR_RST;
            sat_thr = SAT_THR_RST;
            motion_thr = MOTION_THR_RST;
            foreach (last_frame[i])
                last_frame[i] = '0;
            have_last = 1'b0;
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pix_count = 0;
            luma_total = 0;
            square_total = 0;
            dark_hits = 0;
            sat_hits = 0;
            change_hits = 0;
        endfunction

        function void set_threshold(cfg_idx_t idx, cfg_t value);
            case (idx)
                REG_DARK_THR:   dark_thr = value;
                REG_SAT_THR:    sat_thr = value;
                REG_MOTION_THR: motion_thr = value;
                default:        ;
            endcase
        endfunction

        // accumulate one accepted pixel, close the frame on end_of_frame
        function void take_pixel(pix_t p, bit eof, tag_t t);
            int unsigned cur;
            int unsigned old;
            int unsigned diff;
            int unsigned n;
            longint unsigned mean;
            longint unsigned mean_sq;
            result_t r;
            cur = p;
            if (pix_count < MAX_PIXELS)
            begin
                luma_total += cur;
                square_total += cur * cur;
                if (p < dark_thr)
                    dark_hits++;
                if (p > sat_thr)
                    sat_hits++;
                if (have_last)
                begin
                    old = last_frame[pix_count];
                    diff = (cur > old) ? cur - old : old - cur;
                    if (diff > motion_thr)
                        change_hits++;
                end
                last_frame[pix_count] = p;
                pix_count++;
            end
            if (!eof)
                return;
            n = (pix_count == 0) ? 1 : pix_count;
            mean = luma_total / n;
            mean_sq = square_total / n;
            r.frame_tag = t;
            r.mean_luma_x4 = mean4_t'((longint'(luma_total) * 4) / n);
            r.luma_variance = var_t'(mean_sq - mean * mean);
            r.dark_permille = pm_t'((longint'(dark_hits) * 1000) / n);
            r.saturated_permille = pm_t'((longint'(sat_hits) * 1000) / n);
            r.motion_permille = have_last ? pm_t'((longint'(change_hits) * 1000) / n) : '0;
            r.motion_valid = have_last;
            pending_stats.push_back(r);
            have_last = 1'b1;
            clear_frame();
        endfunction

        // compare one frame word with the oldest expectation
        function void compare_stats(result_t got);
            result_t want;
            if (pending_stats.size() == 0)
            begin
                $error("frame word with tag %0d arrived with none expected", got.frame_tag);
                mismatches++;
                return;
            end
            want = pending_stats.pop_front();
            if (got.frame_tag !== want.frame_tag)
            begin
                $error("frame_tag: expected %0d, got %0d", want.frame_tag, got.frame_tag);
                mismatches++;
            end
            if (got.mean_luma_x4 !== want.mean_luma_x4)
            begin
                $error("mean_luma_x4: expected %0d, got %0d",
                       want.mean_luma_x4, got.mean_luma_x4);
                mismatches++;
            end
            if (got.luma_variance !== want.luma_variance)
            begin
                $error("luma_variance: expected %0d, got %0d",
                       want.luma_variance, got.luma_variance);
                mismatches++;
            end
            if (got.dark_permille !== want.dark_permille)
            begin
                $error("dark_permille: expected %0d, got %0d",
                       want.dark_permille, got.dark_permille);
                mismatches++;
            end
            if (got.saturated_permille !== want.saturated_permille)
            begin
                $error("saturated_permille: expected %0d, got %0d",
                       want.saturated_permille, got.saturated_permille);
                mismatches++;
            end
            if (got.motion_permille !== want.motion_permille)
            begin
                $error("motion_permille: expected %0d, got %0d",
                       want.motion_permille, got.motion_permille);
                mismatches++;
            end
            if (got.motion_valid !== want.motion_valid)
            begin
                $error("motion_valid: expected %0d, got %0d",
                       want.motion_valid, got.motion_valid);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_index;
    cfg_t cfg_data;

    lsmd_pixel_if pix ();
    lsmd_result_if stats ();

    frame_stats_tracker tracker;
    int unsigned burst_left;
    int unsigned stall_mode;
    int unsigned stall_left;
    result_t seen;

    luma_stats_motion_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pix),
        .stats_out (stats),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 250 MHz clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // receiver: check accepted frame words, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && stats.valid && stats.ready)
        begin
            seen.frame_tag = stats.frame_tag;
            seen.mean_luma_x4 = stats.mean_luma_x4;
            seen.luma_variance = stats.luma_variance;
            seen.dark_permille = stats.dark_permille;
            seen.saturated_permille = stats.saturated_permille;
            seen.motion_permille = stats.motion_permille;
            seen.motion_valid = stats.motion_valid;
            tracker.compare_stats(seen);
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0:       stats.ready <= 1'b1;
            1:       stats.ready <= 1'($urandom_range(0, 1));
            default: stats.ready <= (stall_left % 8 == 0);
        endcase
    end

    function automatic pix_t clamp_pix(int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return 8'hFF;
        return pix_t'(v);
    endfunction

    // random pixel biased toward the threshold edges and the stored frame
    function automatic pix_t pick_pixel();
        int old;
        int step;
        old = (tracker.pix_count < MAX_PIXELS) ? int'(tracker.last_frame[tracker.pix_count]) : 0;
        step = int'(tracker.motion_thr) + int'($urandom_range(0, 2)) - 1;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 8'hFF;
            2:       return clamp_pix(int'(tracker.dark_thr) + int'($urandom_range(0, 2)) - 1);
            3:       return clamp_pix(int'(tracker.sat_thr) + int'($urandom_range(0, 2)) - 1);
            4, 5, 6: return clamp_pix($urandom_range(0, 1) ? old + step : old - step);
            default: return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // one pixel word, sent in bursts with random gaps in between
    task automatic send_pixel(pix_t p, bit eof, tag_t t);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                pix.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        pix.valid <= 1'b1;
        pix.pixel <= p;
        pix.end_of_frame <= eof;
        pix.frame_number <= t;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        tracker.take_pixel(p, eof, t);
    endtask

    task automatic send_list(pix_t vals [$], tag_t t);
        foreach (vals[i])
            send_pixel(vals[i], i == vals.size() - 1, t);
    endtask

    task automatic send_random_frame(int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_pixel(pick_pixel(), i == len - 1, tag_t'($urandom));
    endtask

    // drop valid and let every frame word drain before touching the registers
    task automatic settle();
        pix.valid <= 1'b0;
        while (tracker.pending_stats.size() != 0)
            @(posedge clk);
        repeat (EOF_SETTLE) @(posedge clk);
    endtask

    // write all three thresholds plus the unused index
    task automatic write_thresholds(cfg_t dark, cfg_t sat, cfg_t motion);
        cfg_idx_t idx [4];
        cfg_t val [4];
        idx = '{REG_SPARE, REG_DARK_THR, REG_SAT_THR, REG_MOTION_THR};
        val = '{cfg_t'($urandom), dark, sat, motion};
        foreach (idx[i])
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            tracker.set_threshold(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // watchdog
    initial
    begin
        #5_000_000;
        $display("luma_stats_motion_detector verification failed");
        $finish;
    end

    initial
    begin
        int unsigned words;
        int unsigned len;
        tracker = new();
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_DARK_THR;
        cfg_data <= '0;
        pix.valid <= 1'b0;
        pix.pixel <= '0;
        pix.end_of_frame <= 1'b0;
        pix.frame_number <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames on reset thresholds: first frame has no motion,
        // then threshold edges, a one-pixel frame and an all-black frame
        send_list('{8'd0, 8'd255, 8'd15, 8'd16, 8'd240, 8'd241, 8'd128, 8'd127}, '0);
        send_list('{8'd12, 8'd242, 8'd28, 8'd4, 8'd240, 8'd241, 8'd128, 8'd127}, '1);
        send_list('{8'd255}, tag_t'($urandom));
        send_list('{8'd0, 8'd0, 8'd0}, tag_t'($urandom));
        settle();

        // random frames of mixed size under extreme and random thresholds
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       write_thresholds(8'd0, 8'd255, 8'd0);
                1:       write_thresholds(8'd255, 8'd0, 8'd255);
                default: write_thresholds(cfg_t'($urandom), cfg_t'($urandom),
                                          cfg_t'($urandom_range(0, 40)));
            endcase
            words = 0;
            while (words < PHASE_WORDS)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 60)
                                                  : $urandom_range(1, 16);
                send_random_frame(len);
                words += len;
            end
            settle();
        end

        if (tracker.mismatches == 0)
            $display("luma_stats_motion_detector verification clean");
        else
            $display("luma_stats_motion_detector verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/lsmd_pkg.sv
design/lsmd_pixel_if.sv
design/lsmd_result_if.sv
design/lsmd_ram.sv
design/lsmd_div.sv
design/lsmd_datapath.sv
design/lsmd_ctrl.sv
design/luma_stats_motion_detector.sv
tb/luma_stats_motion_detector_tb.sv
